// ===== hw/rtl/cfct_pkg.sv =====
// ----------------------------------------------------------------------------
// cfct_pkg
// Shared types and constants of the CAN frame change tracker.
// ----------------------------------------------------------------------------
package cfct_pkg;

    typedef enum logic [2:0] {
        CMD_FRAME    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_CLR_CHG  = 3'd2,
        CMD_CLR_DSC  = 3'd3,
        CMD_CLR_TAB  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_DISCOVER  = 3'd1,
        ST_NEW       = 3'd2,
        ST_FULL      = 3'd3,
        ST_READ      = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CFG_MODE     = 3'd0,
        CFG_STD_MIN  = 3'd1,
        CFG_STD_MAX  = 3'd2,
        CFG_EXT_MIN  = 3'd3,
        CFG_EXT_MAX  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_REQ     = 2'd1,
        KIND_RESP    = 2'd2
    } kind_t;

    localparam logic [7:0]  OBD_RESP_PID16 = 8'h4a;
    localparam logic [7:0]  OBD_RESP_BASE  = 8'h40;
    localparam logic [7:0]  OBD_REQ_PID16  = 8'h0a;
    localparam logic [7:0]  OBD_PCI_MAX    = 8'd8;
    localparam logic [3:0]  LEN_MAX        = 4'd8;
    localparam logic [31:0] COUNT_MAX      = 32'hffff_ffff;

    localparam logic [17:0] MARKS_NEW_ANA  = 18'h100ff;
    localparam logic [17:0] MARKS_NEW_DSC  = 18'h3ffff;
    localparam logic [17:0] MARKS_CHG_ALL  = 18'h100ff;
    localparam logic [17:0] MARKS_DSC_ALL  = 18'h2ff00;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  mode;
        logic [1:0]  kind;
        logic [28:0] id;
        logic        ext;
        logic [2:0]  bus;
    } key_t;

    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  len;
        logic [31:0] count;
        logic [17:0] marks;
    } entry_t;

    typedef struct packed {
        logic        mode;
        logic [10:0] std_min;
        logic [10:0] std_max;
        logic [28:0] ext_min;
        logic [28:0] ext_max;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  index;
        key_t        key;
        entry_t      data;
    } result_t;

endpackage

// ===== hw/rtl/cfct_ram.sv =====
// ----------------------------------------------------------------------------
// cfct_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/cfct_keygen.sv =====
// ----------------------------------------------------------------------------
// cfct_keygen
// Builds the lookup key of a frame, with OBD-II kind, mode and PID.
// ----------------------------------------------------------------------------
module cfct_keygen
    import cfct_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [2:0]  bus,
    input  logic        extended,
    input  logic [28:0] can_id,
    input  logic [63:0] payload,
    output key_t        key
);

    logic       obd;
    logic [7:0] b0, b1, b2, b3;

    assign b0 = payload[7:0];
    assign b1 = payload[15:8];
    assign b2 = payload[23:16];
    assign b3 = payload[31:24];

    always_comb
    begin
        obd = 1'b0;
        if (!extended && cfg.std_min != 11'd0 && can_id >= 29'(cfg.std_min)
            && can_id <= 29'(cfg.std_max))
        begin
            obd = 1'b1;
        end
        if (extended && cfg.ext_min != 29'd0 && can_id >= cfg.ext_min
            && can_id <= cfg.ext_max)
        begin
            obd = 1'b1;
        end

        key      = '0;
        key.bus  = bus;
        key.ext  = extended;
        key.id   = can_id;
        if (obd && b0 <= OBD_PCI_MAX)
        begin
            if (b1 > OBD_RESP_PID16)
            begin
                key.kind = KIND_RESP;
                key.mode = b1 - OBD_RESP_BASE;
                key.pid  = {b2, b3};
            end
            else if (b1 > OBD_RESP_BASE)
            begin
                key.kind = KIND_RESP;
                key.mode = b1 - OBD_RESP_BASE;
                key.pid  = {8'd0, b2};
            end
            else if (b1 > OBD_REQ_PID16)
            begin
                key.kind = KIND_REQ;
                key.mode = b1;
                key.pid  = {b2, b3};
            end
            else
            begin
                key.kind = KIND_REQ;
                key.mode = b1;
                key.pid  = {8'd0, b2};
            end
        end
    end

endmodule

// ===== hw/rtl/cfct_merge.sv =====
// ----------------------------------------------------------------------------
// cfct_merge
// Compares a frame with the stored one and updates marks, data and count.
// ----------------------------------------------------------------------------
module cfct_merge
    import cfct_pkg::*;
(
    input  logic        mode,
    input  entry_t      old_data,
    input  logic [63:0] payload,
    input  logic [3:0]  len,
    output entry_t      new_data,
    output logic        found
);

    logic [7:0] diff;
    logic [7:0] fresh;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            diff[k] = (4'(k) < old_data.len)
                      && (old_data.payload[8*k +: 8] != payload[8*k +: 8]);
        end
        fresh = diff & ~old_data.marks[7:0];

        new_data         = old_data;
        new_data.payload = payload;
        new_data.len     = len;
        if (old_data.count != COUNT_MAX)
        begin
            new_data.count = old_data.count + 32'd1;
        end
        if (mode)
        begin
            new_data.marks[7:0]  = old_data.marks[7:0] | fresh;
            new_data.marks[15:8] = old_data.marks[15:8] | fresh;
            found                = |fresh;
        end
        else
        begin
            new_data.marks[7:0] = old_data.marks[7:0] | diff;
            found               = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/can_frame_change_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// can_frame_change_tracker_unit
// Keys CAN frames, tracks changed and discovered bytes per key in a table.
// ----------------------------------------------------------------------------
// Frame: the key scan reads one entry per cycle from the key RAM over the n
//   entries in use; a miss appends a new entry unless the table is full, a hit
//   on entry j does a read-modify-write of the data RAM entry. Read: one read
//   of each RAM. Clear marks: one read and one write of the data RAM per
//   entry. Clear table and unknown commands answer straight from idle.
// One command in flight; the next is taken once busy drops. done pulses one
//   cycle with the result, the receiver cannot stall it.
// Reset empties the table (fill count to zero) and clears config registers.
module can_frame_change_tracker_unit
    import cfct_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [2:0]  bus,
    input  logic        extended,
    input  logic [28:0] can_id,
    input  logic [3:0]  length,
    input  logic [63:0] payload,
    input  logic [7:0]  entry_select,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // result
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  entry_index,
    output logic [2:0]  key_bus,
    output logic        key_extended,
    output logic [28:0] key_id,
    output logic [1:0]  key_kind,
    output logic [7:0]  key_mode,
    output logic [15:0] key_pid,
    output logic [63:0] last_payload,
    output logic [3:0]  last_length,
    output logic [31:0] rx_count,
    output logic [17:0] marks
);

    localparam int IW = $clog2(TABLE_DEPTH);          // entry address width
    localparam int CW = $clog2(TABLE_DEPTH + 1);      // fill count width
    localparam int SW = (CW > 8) ? CW : 8;            // select compare width
    localparam int KW = $bits(key_t);
    localparam int DW = $bits(entry_t);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_HIT  = 6'b000100,
        S_READ = 6'b001000,
        S_SWRD = 6'b010000,
        S_SWWR = 6'b100000
    } state_t;

    state_t          state_reg, state_next;
    cfg_t            cfg_reg, cfg_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [CW-1:0]   issue_reg, issue_next;     // scan read pointer / sweep pointer
    logic            cmp_v_reg, cmp_v_next;     // key read data is valid this cycle
    logic [IW-1:0]   cmp_addr_reg, cmp_addr_next;
    logic [IW-1:0]   idx_reg, idx_next;         // hit entry or read entry
    key_t            key_reg, key_next;
    logic [63:0]     pay_reg, pay_next;
    logic [3:0]      len_reg, len_next;
    logic [17:0]     clr_reg, clr_next;         // marks to clear during a sweep
    logic            done_reg, done_next;
    result_t         res_reg, res_next;

    key_t            key_in;
    logic            key_we, key_re;
    logic [IW-1:0]   key_waddr, key_raddr;
    key_t            key_wdata, key_rdata;
    logic            data_we, data_re;
    logic [IW-1:0]   data_waddr, data_raddr;
    entry_t          data_wdata, data_rdata, merged;
    logic            found;
    logic            match, scan_end;

    cfct_keygen u_keygen (
        .cfg      (cfg_reg),
        .bus      (bus),
        .extended (extended),
        .can_id   (can_id),
        .payload  (payload),
        .key      (key_in)
    );

    cfct_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    cfct_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    cfct_merge u_merge (
        .mode     (cfg_reg.mode),
        .old_data (data_rdata),
        .payload  (pay_reg),
        .len      (len_reg),
        .new_data (merged),
        .found    (found)
    );

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);

    // scan compare stage: one stored key per cycle
    assign match    = cmp_v_reg && (key_rdata == key_reg);
    assign scan_end = (used_reg == '0)
                      || (cmp_v_reg && !match && (CW'(cmp_addr_reg) + CW'(1) == used_reg));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:    cfg_next.mode    = cfg_data[0];
                CFG_STD_MIN: cfg_next.std_min = cfg_data[10:0];
                CFG_STD_MAX: cfg_next.std_max = cfg_data[10:0];
                CFG_EXT_MIN: cfg_next.ext_min = cfg_data[28:0];
                CFG_EXT_MAX: cfg_next.ext_max = cfg_data[28:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        issue_next    = issue_reg;
        cmp_v_next    = 1'b0;
        cmp_addr_next = cmp_addr_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        len_next      = len_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        res_next      = res_reg;

        key_we     = 1'b0;
        key_waddr  = used_reg[IW-1:0];
        key_wdata  = key_reg;
        key_re     = 1'b0;
        key_raddr  = issue_reg[IW-1:0];
        data_we    = 1'b0;
        data_waddr = idx_reg;
        data_wdata = merged;
        data_re    = 1'b0;
        data_raddr = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_FRAME:
                        begin
                            key_next   = key_in;
                            pay_next   = payload;
                            len_next   = (length > LEN_MAX) ? LEN_MAX : length;
                            issue_next = '0;
                            state_next = S_SCAN;
                        end
                        CMD_READ:
                        begin
                            if (SW'(entry_select) < SW'(used_reg))
                            begin
                                key_re     = 1'b1;
                                key_raddr  = IW'(entry_select);
                                data_re    = 1'b1;
                                data_raddr = IW'(entry_select);
                                idx_next   = IW'(entry_select);
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next        = '0;
                                res_next.status = ST_EMPTY;
                                done_next       = 1'b1;
                            end
                        end
                        CMD_CLR_CHG, CMD_CLR_DSC:
                        begin
                            clr_next   = (cmd == CMD_CLR_CHG) ? MARKS_CHG_ALL : MARKS_DSC_ALL;
                            issue_next = '0;
                            state_next = S_SWRD;
                        end
                        CMD_CLR_TAB:
                        begin
                            used_next       = '0;
                            res_next        = '0;
                            res_next.status = ST_CLEARED;
                            done_next       = 1'b1;
                        end
                        default:
                        begin
                            res_next        = '0;
                            res_next.status = ST_EMPTY;
                            done_next       = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue_reg < used_reg)
                begin
                    key_re        = 1'b1;
                    issue_next    = issue_reg + CW'(1);
                    cmp_v_next    = 1'b1;
                    cmp_addr_next = issue_reg[IW-1:0];
                end
                if (match)
                begin
                    data_re    = 1'b1;
                    data_raddr = cmp_addr_reg;
                    idx_next   = cmp_addr_reg;
                    cmp_v_next = 1'b0;
                    state_next = S_HIT;
                end
                else if (scan_end)
                begin
                    cmp_v_next = 1'b0;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = '0;
                    if (used_reg == CW'(TABLE_DEPTH))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        // new entry: every byte marked changed
                        data_wdata.payload = pay_reg;
                        data_wdata.len     = len_reg;
                        data_wdata.count   = 32'd1;
                        data_wdata.marks   = cfg_reg.mode ? MARKS_NEW_DSC : MARKS_NEW_ANA;
                        key_we             = 1'b1;
                        data_we            = 1'b1;
                        data_waddr         = used_reg[IW-1:0];
                        used_next          = used_reg + CW'(1);
                        res_next.status    = ST_NEW;
                        res_next.index     = 8'(used_reg[IW-1:0]);
                        res_next.key       = key_reg;
                        res_next.data      = data_wdata;
                    end
                end
            end
            S_HIT:
            begin
                data_we         = 1'b1;
                res_next.status = found ? ST_DISCOVER : ST_UPDATED;
                res_next.index  = 8'(idx_reg);
                res_next.key    = key_reg;
                res_next.data   = merged;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_READ:
            begin
                res_next.status = ST_READ;
                res_next.index  = 8'(idx_reg);
                res_next.key    = key_rdata;
                res_next.data   = data_rdata;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_SWRD:
            begin
                if (issue_reg < used_reg)
                begin
                    data_re    = 1'b1;
                    data_raddr = issue_reg[IW-1:0];
                    state_next = S_SWWR;
                end
                else
                begin
                    res_next        = '0;
                    res_next.status = ST_CLEARED;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_SWWR:
            begin
                data_we          = 1'b1;
                data_waddr       = issue_reg[IW-1:0];
                data_wdata       = data_rdata;
                data_wdata.marks = data_rdata.marks & ~clr_reg;
                issue_next       = issue_reg + CW'(1);
                state_next       = S_SWRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= '0;
            used_reg  <= '0;
            issue_reg <= '0;
            cmp_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cfg_reg   <= cfg_next;
            used_reg  <= used_next;
            issue_reg <= issue_next;
            cmp_v_reg <= cmp_v_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= cmp_addr_next;
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        len_reg      <= len_next;
        clr_reg      <= clr_next;
        res_reg      <= res_next;
    end

    assign done         = done_reg;
    assign status       = res_reg.status;
    assign entry_index  = res_reg.index;
    assign key_bus      = res_reg.key.bus;
    assign key_extended = res_reg.key.ext;
    assign key_id       = res_reg.key.id;
    assign key_kind     = res_reg.key.kind;
    assign key_mode     = res_reg.key.mode;
    assign key_pid      = res_reg.key.pid;
    assign last_payload = res_reg.data.payload;
    assign last_length  = res_reg.data.len;
    assign rx_count     = res_reg.data.count;
    assign marks        = res_reg.data.marks;

endmodule

// ===== hw/rtl/cfct_checker.sv =====
// ----------------------------------------------------------------------------
// cfct_checker
// Port-level checks of the change tracker, bound to the top level.
// ----------------------------------------------------------------------------
module cfct_checker
    import cfct_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [28:0] key_id,
    input logic [31:0] rx_count,
    input logic [17:0] marks
);

    // a result beat always leaves the unit idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    // an accepted beat either starts work or answers at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done)) else $error("command lost");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_CLEARED)) else $error("bad status");

    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL || status == ST_EMPTY || status == ST_CLEARED))
        |-> (key_id == '0 && rx_count == '0 && marks == '0))
        else $error("blank result not zero");

    a_new: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_NEW) |-> (rx_count == 32'd1 && marks[7:0] == 8'hff))
        else $error("new entry not initialized");

endmodule

bind can_frame_change_tracker_unit cfct_checker u_cfct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .key_id   (key_id),
    .rx_count (rx_count),
    .marks    (marks)
);

// ===== tb/cfct_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfct_scoreboard
// Watches the command, config and result channels of the change tracker,
// mirrors its key table and checks every result beat field by field.
// ----------------------------------------------------------------------------
module cfct_scoreboard
    import cfct_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  cmd,
    input  logic [2:0]  bus,
    input  logic        extended,
    input  logic [28:0] can_id,
    input  logic [3:0]  length,
    input  logic [63:0] payload,
    input  logic [7:0]  entry_select,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [7:0]  entry_index,
    input  logic [2:0]  key_bus,
    input  logic        key_extended,
    input  logic [28:0] key_id,
    input  logic [1:0]  key_kind,
    input  logic [7:0]  key_mode,
    input  logic [15:0] key_pid,
    input  logic [63:0] last_payload,
    input  logic [3:0]  last_length,
    input  logic [31:0] rx_count,
    input  logic [17:0] marks,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    cfg_t    cfg;
    logic    ent_valid [DEPTH];
    key_t    ent_key   [DEPTH];
    entry_t  ent_data  [DEPTH];
    int      ent_used;
    result_t pending_results [$];

    assign pending = pending_results.size();

    function automatic logic [7:0] byte_at(logic [63:0] p, int k);
        return p[8*k +: 8];
    endfunction

    function automatic key_t build_key(logic [2:0] b, logic e, logic [28:0] id,
                                       logic [63:0] p);
        key_t k;
        logic obd;
        logic [7:0] m;
        k = '0;
        k.bus = b;
        k.ext = e;
        k.id  = id;
        obd = (!e && cfg.std_min != 0 && id <= 29'(cfg.std_max) &&
               id >= 29'(cfg.std_min)) ||
              (e && cfg.ext_min != 0 && id >= cfg.ext_min && id <= cfg.ext_max);
        if (obd && byte_at(p, 0) <= OBD_PCI_MAX)
        begin
            m = byte_at(p, 1);
            if (m > OBD_RESP_PID16)
            begin
                k.kind = KIND_RESP; k.mode = m - OBD_RESP_BASE;
                k.pid = {byte_at(p, 2), byte_at(p, 3)};
            end
            else if (m > OBD_RESP_BASE)
            begin
                k.kind = KIND_RESP; k.mode = m - OBD_RESP_BASE;
                k.pid = {8'h00, byte_at(p, 2)};
            end
            else if (m > OBD_REQ_PID16)
            begin
                k.kind = KIND_REQ; k.mode = m;
                k.pid = {byte_at(p, 2), byte_at(p, 3)};
            end
            else
            begin
                k.kind = KIND_REQ; k.mode = m;
                k.pid = {8'h00, byte_at(p, 2)};
            end
        end
        return k;
    endfunction

    function automatic result_t entry_result(logic [2:0] st, int i);
        result_t r;
        r.status = st;
        r.index  = i[7:0];
        r.key    = ent_key[i];
        r.data   = ent_data[i];
        return r;
    endfunction

    function automatic result_t blank_result(logic [2:0] st);
        result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    // Updates the mirrored table for one frame and returns the result beat.
    function automatic result_t track_frame();
        key_t k;
        logic [3:0] len;
        int i, n, hit_at;
        logic found;
        logic made;
        logic [17:0] bit_m;
        k = build_key(bus, extended, can_id, payload);
        len = (length > LEN_MAX) ? LEN_MAX : length;
        hit_at = -1;
        found = 1'b0;
        made = 1'b0;
        for (i = 0; i < ent_used; i++)
            if (hit_at < 0 && ent_valid[i] && ent_key[i] == k) hit_at = i;
        if (hit_at < 0)
        begin
            if (ent_used >= DEPTH) return blank_result(ST_FULL);
            hit_at = ent_used;
            ent_used++;
            made = 1'b1;
            ent_valid[hit_at] = 1'b1;
            ent_key[hit_at] = k;
            ent_data[hit_at].count = '0;
            ent_data[hit_at].marks = cfg.mode ? MARKS_NEW_DSC : MARKS_NEW_ANA;
        end
        else
        begin
            n = ent_data[hit_at].len;
            for (i = 0; i < n; i++)
            begin
                bit_m = 18'(1) << i;
                if (byte_at(ent_data[hit_at].payload, i) != byte_at(payload, i))
                begin
                    if (!cfg.mode)
                        ent_data[hit_at].marks |= bit_m;
                    else if ((ent_data[hit_at].marks & bit_m) == 0)
                    begin
                        ent_data[hit_at].marks |= bit_m | (bit_m << 8);
                        found = 1'b1;
                    end
                end
            end
        end
        ent_data[hit_at].payload = payload;
        ent_data[hit_at].len = len;
        if (ent_data[hit_at].count != COUNT_MAX) ent_data[hit_at].count++;
        return entry_result(made ? ST_NEW : (found ? ST_DISCOVER : ST_UPDATED), hit_at);
    endfunction

    function automatic result_t predict();
        logic [17:0] clr;
        int i;
        case (cmd)
            CMD_FRAME:
                return track_frame();
            CMD_READ:
                if (entry_select < ent_used && ent_valid[entry_select])
                    return entry_result(ST_READ, entry_select);
                else
                    return blank_result(ST_EMPTY);
            CMD_CLR_CHG, CMD_CLR_DSC:
            begin
                clr = (cmd == CMD_CLR_CHG) ? MARKS_CHG_ALL : MARKS_DSC_ALL;
                for (i = 0; i < DEPTH; i++)
                    if (ent_valid[i]) ent_data[i].marks &= ~clr;
                return blank_result(ST_CLEARED);
            end
            CMD_CLR_TAB:
            begin
                for (i = 0; i < DEPTH; i++) ent_valid[i] = 1'b0;
                ent_used = 0;
                return blank_result(ST_CLEARED);
            end
            default: return blank_result(ST_EMPTY);
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $realtime, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            cfg = '0;
            ent_used = 0;
            for (int i = 0; i < DEPTH; i++) ent_valid[i] = 1'b0;
            pending_results.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            // result beat first: it belongs to a command already queued
            if (done)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, status %0d",
                             $realtime, status);
                    fail_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("status", e.status, status);
                    check_field("entry_index", e.index, entry_index);
                    check_field("key_bus", e.key.bus, key_bus);
                    check_field("key_extended", e.key.ext, key_extended);
                    check_field("key_id", e.key.id, key_id);
                    check_field("key_kind", e.key.kind, key_kind);
                    check_field("key_mode", e.key.mode, key_mode);
                    check_field("key_pid", e.key.pid, key_pid);
                    check_field("last_payload", e.data.payload, last_payload);
                    check_field("last_length", e.data.len, last_length);
                    check_field("rx_count", e.data.count, rx_count);
                    check_field("marks", e.data.marks, marks);
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_MODE:    cfg.mode    = cfg_data[0];
                    CFG_STD_MIN: cfg.std_min = cfg_data[10:0];
                    CFG_STD_MAX: cfg.std_max = cfg_data[10:0];
                    CFG_EXT_MIN: cfg.ext_min = cfg_data[28:0];
                    CFG_EXT_MAX: cfg.ext_max = cfg_data[28:0];
                    default: ;
                endcase
            if (start && !busy)
                pending_results.push_back(predict());
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands and config writes into the CAN change tracker through
// several OBD-II range and mode settings; the scoreboard does the checking.
// ----------------------------------------------------------------------------
module testbench
    import cfct_pkg::*;
;

    localparam int DEPTH       = 256;
    // slowest command: clear marks over a full table, plus slack
    localparam int DRAIN_WAIT  = 2 * DEPTH + 40;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RAND_ITEMS  = 1500;
    localparam int CALM_ITEMS  = 200;   // tail with no idling

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [2:0]  bus;
    logic        extended;
    logic [28:0] can_id;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [7:0]  entry_select;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [2:0]  status;
    logic [7:0]  entry_index;
    logic [2:0]  key_bus;
    logic        key_extended;
    logic [28:0] key_id;
    logic [1:0]  key_kind;
    logic [7:0]  key_mode;
    logic [15:0] key_pid;
    logic [63:0] last_payload;
    logic [3:0]  last_length;
    logic [31:0] rx_count;
    logic [17:0] marks;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent;
    int cycles;
    logic idle_on;               // random idling allowed
    logic [29:0] id_pool   [16]; // small key pool so frames hit often; bit 29 = extended
    logic [63:0] data_pool [16];

    can_frame_change_tracker_unit #(.TABLE_DEPTH(DEPTH)) dut (.*);

    cfct_scoreboard #(.DEPTH(DEPTH)) scoreboard (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run guard: a hang anywhere ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // random idle gap before some beats, start held low
    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // one command beat; start stays high when the next beat follows at once
    task automatic send(logic [2:0] c, logic [2:0] b, logic e, logic [28:0] id,
                        logic [3:0] l, logic [63:0] p, logic [7:0] sel);
        maybe_idle();
        cmd = c; bus = b; extended = e; can_id = id;
        length = l; payload = p; entry_select = sel;
        start = 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic frame(logic [2:0] b, logic e, logic [28:0] id, logic [3:0] l,
                         logic [63:0] p);
        send(CMD_FRAME, b, e, id, l, p, 8'($urandom));
    endtask

    task automatic simple(logic [2:0] c, logic [7:0] sel);
        send(c, 3'($urandom), 1'($urandom), 29'($urandom), 4'($urandom),
             {$urandom, $urandom}, sel);
    endtask

    // hold off until every result has come, then let the block settle
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(logic md, logic [31:0] smin, logic [31:0] smax,
                         logic [31:0] emin, logic [31:0] emax);
        drain();
        cfg_write(CFG_MODE, {31'($urandom), md});
        cfg_write(CFG_STD_MIN, smin);
        cfg_write(CFG_STD_MAX, smax);
        cfg_write(CFG_EXT_MIN, emin);
        cfg_write(CFG_EXT_MAX, emax);
    endtask

    // OBD-style payload: PCI byte, service byte, PID bytes, random rest
    function automatic logic [63:0] obd_data(logic [7:0] pci, logic [7:0] svc);
        return {$urandom, 8'($urandom), 8'($urandom), svc, pci};
    endfunction

    task automatic refill_pools(logic [28:0] std_lo, logic [28:0] ext_lo);
        for (int i = 0; i < 16; i++)
        begin
            // half near the OBD windows, half anywhere
            case (i % 4)
                0: id_pool[i] = {1'b0, 29'(std_lo + $urandom_range(0, 8))};
                1: id_pool[i] = {1'b1, 29'(ext_lo + $urandom_range(0, 8))};
                2: id_pool[i] = {1'b0, 29'($urandom_range(0, 2047))};
                default: id_pool[i] = {1'b1, 29'($urandom)};
            endcase
            data_pool[i] = obd_data(8'($urandom_range(0, 9)), 8'($urandom));
        end
    endtask

    // mostly repeated keys with a few bytes flipped, plus noise commands
    task automatic random_items(int count, logic [28:0] std_lo, logic [28:0] ext_lo);
        int slot;
        int pick;
        logic [63:0] d;
        refill_pools(std_lo, ext_lo);
        for (int n = 0; n < count; n++)
        begin
            if (items_sent >= 25 + RAND_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, 15);
            if (pick < 70)
            begin
                d = data_pool[slot];
                // flip bytes 4..7 freely; bytes 0..3 rarely since they form keys
                d[63:32] = ($urandom_range(0, 1)) ? d[63:32] ^ (32'hff << (8 *
                           $urandom_range(0, 3))) : d[63:32];
                if ($urandom_range(0, 9) == 0) d[31:0] = $urandom;
                data_pool[slot] = d;
                frame(id_pool[slot][2:0] ^ 3'($urandom_range(0, 9) == 0),
                      id_pool[slot][29], id_pool[slot][28:0],
                      $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 8)),
                      d);
            end
            else if (pick < 78)
                frame(3'($urandom), 1'($urandom), 29'($urandom), 4'($urandom),
                      {$urandom, $urandom});
            else if (pick < 90)
                simple(CMD_READ, $urandom_range(0, 1) ? 8'($urandom_range(0, 20))
                                                      : 8'($urandom));
            else if (pick < 94)
                simple(CMD_CLR_CHG, 8'($urandom));
            else if (pick < 97)
                simple(CMD_CLR_DSC, 8'($urandom));
            else if (pick < 98)
                simple(CMD_CLR_TAB, 8'($urandom));
            else
                simple(3'($urandom_range(5, 7)), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_FRAME; bus = '0; extended = 1'b0; can_id = '0;
        length = '0; payload = '0; entry_select = '0;
        cfg_valid = 1'b0; cfg_index = CFG_MODE; cfg_data = '0;
        cycles = 0;
        items_sent = 0;
        idle_on = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every key branch, field extremes, all commands
        setup(1'b0, 32'h7df, 32'h7ef, 32'h18da_f100, 32'h18db_ffff);
        frame(3'd7, 1'b1, 29'h1fff_ffff, 4'd15, '1);
        frame(3'd7, 1'b1, 29'h1fff_ffff, 4'd15, '0);
        frame(3'd0, 1'b0, 29'd0, 4'd0, '1);
        frame(3'd0, 1'b0, 29'd0, 4'd8, 64'h0102);
        frame(3'd1, 1'b0, 29'h7df, 4'd8, 64'h1122_3344_0d0c_4b02); // resp, pid16
        frame(3'd1, 1'b0, 29'h7df, 4'd8, 64'h1122_3344_0d0c_4102); // resp, pid8
        frame(3'd1, 1'b0, 29'h7ef, 4'd8, 64'h1122_3344_0d0c_0b02); // req, pid16
        frame(3'd1, 1'b0, 29'h7e8, 4'd8, 64'h1122_3344_0d0c_0a02); // req, pid8
        frame(3'd1, 1'b0, 29'h7e8, 4'd8, 64'h1122_3344_0d0c_0a09); // PCI over 8
        frame(3'd2, 1'b1, 29'h18da_f100, 4'd3, 64'h00ff_00ff_00ff_0108);
        frame(3'd2, 1'b1, 29'h18da_f100, 4'd8, 64'hff00_ff00_ff00_0108);
        frame(3'd2, 1'b1, 29'h18da_f100, 4'd8, 64'h0000_0000_0000_0108);
        simple(CMD_READ, 8'd0);
        simple(CMD_READ, 8'd255);
        simple(CMD_CLR_CHG, 8'd0);
        simple(CMD_READ, 8'd1);
        simple(3'd5, 8'd0);
        simple(3'd7, 8'd0);
        setup(1'b1, 32'h7df, 32'h7ef, 32'h18da_f100, 32'h18db_ffff);
        frame(3'd2, 1'b1, 29'h18da_f100, 4'd8, 64'h5555_0000_0000_0108);
        frame(3'd2, 1'b1, 29'h18da_f100, 4'd8, 64'h5555_0000_0000_0108);
        frame(3'd5, 1'b0, 29'h123, 4'd8, 64'h0);
        simple(CMD_CLR_DSC, 8'd0);
        simple(CMD_READ, 8'd2);
        simple(CMD_CLR_TAB, 8'd0);
        simple(CMD_READ, 8'd0);

        // random phases across settings, extremes among them
        idle_on = 1'b1;
        setup(1'b0, 32'h7df, 32'h7ef, 32'h18da_f100, 32'h18db_ffff);
        random_items(350, 29'h7df, 29'h18da_f100);
        setup(1'b1, 32'h7df, 32'h7ef, 32'h18da_f100, 32'h18db_ffff);
        random_items(350, 29'h7df, 29'h18da_f100);
        setup(1'b1, 32'h0, 32'h7ff, 32'h1, 32'h1fff_ffff);
        random_items(300, 29'h0, 29'h1);
        setup(1'b0, 32'h1, 32'h7ff, 32'h0, 32'h1fff_ffff);
        random_items(300, 29'h1, 29'h0);

        // fill the table past its depth so new keys are dropped
        setup(1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        simple(CMD_CLR_TAB, 8'd0);
        for (int i = 0; i < DEPTH + 4; i++)
            frame(3'd3, 1'b1, 29'(i), 4'd8, {$urandom, $urandom});
        simple(CMD_READ, 8'd255);
        simple(CMD_CLR_CHG, 8'd0);
        frame(3'd3, 1'b1, 29'd7, 4'd8, '1);
        simple(CMD_CLR_TAB, 8'd0);

        // calm tail, no idling
        setup(1'b1, 32'h7e0, 32'h7ff, 32'h18da_0000, 32'h18da_ffff);
        idle_on = 1'b0;
        random_items(CALM_ITEMS, 29'h7e0, 29'h18da_0000);

        drain();
        $display("Sent %0d command beats over several config settings, got %0d result beats.",
                 items_sent, results_seen);
        $display("Covered OBD-II key kinds, analyse and discover marks, full table.");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
